>>> sv/rpfr_pkg.sv
package rpfr_pkg;

    localparam int POS_WIDTH_DEF    = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int VEC_W    = 16;
    localparam int ROT_W    = 15;
    localparam int ANG_W    = 14;
    localparam int ANG_MAX  = 11520;
    localparam int ANG_QUARTER = 1474560;
    localparam int TABLE_LEN = 24;

    // Operand, accumulator and unit widths.
    localparam int OPW     = 34;
    localparam int ACCW    = 2 * OPW;
    localparam int SQ_W    = 64;
    localparam int SQ_STEPS = 32;
    localparam int CD_W    = 36;
    localparam int Z_W     = 24;
    localparam int ATAN_W  = 20;
    localparam int STEP_W  = 5;
    localparam int UOP_W   = 6;

    localparam logic [UOP_W-1:0] UOP_X_LAST  = 6'd22;
    localparam logic [UOP_W-1:0] UOP_Y_FIRST = 6'd23;
    localparam logic [UOP_W-1:0] UOP_Y_LAST  = 6'd37;

    typedef enum logic [4:0] {
        SRC_N0X, SRC_N0Y, SRC_N0Z,
        SRC_T0X, SRC_T0Y, SRC_T0Z,
        SRC_NX,  SRC_NY,  SRC_NZ,
        SRC_TX,  SRC_TY,  SRC_TZ,
        SRC_C0,  SRC_C1,  SRC_C2,
        SRC_DA,  SRC_DB,  SRC_DC, SRC_DD
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_C0, DST_C1, DST_C2,
        DST_DA, DST_DB, DST_DC, DST_DD,
        DST_SQ, DST_SGN
    } dst_t;

    typedef struct packed {
        src_t a;
        src_t b;
        logic neg;
        logic first;
        logic shr2;
        dst_t dst;
    } uop_t;

    typedef struct packed {
        logic             accept;
        logic             mac;
        logic [UOP_W-1:0] uop;
        logic             sq_init;
        logic             sq_step;
        logic             cd_init;
        logic             cd_step;
        logic [STEP_W-1:0] step;
        logic             keep_x;
        logic             keep_y;
        logic             load_out;
    } cmd_t;

    function automatic int in_dw(input int pos_width);
        return ((3 * pos_width + 6 * VEC_W + 7) / 8) * 8;
    endfunction

    function automatic int out_dw(input int pos_width);
        return ((3 * pos_width + 2 * ROT_W + 7) / 8) * 8;
    endfunction

    // atan(2^-i) in units of 1/16384 degree, rounded to nearest.
    function automatic logic [ATAN_W-1:0] atan_fine(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:  v = 20'd737280;
            5'd1:  v = 20'd435242;
            5'd2:  v = 20'd229970;
            5'd3:  v = 20'd116736;
            5'd4:  v = 20'd58595;
            5'd5:  v = 20'd29326;
            5'd6:  v = 20'd14667;
            5'd7:  v = 20'd7334;
            5'd8:  v = 20'd3667;
            5'd9:  v = 20'd1833;
            5'd10: v = 20'd917;
            5'd11: v = 20'd458;
            5'd12: v = 20'd229;
            5'd13: v = 20'd115;
            5'd14: v = 20'd57;
            5'd15: v = 20'd29;
            5'd16: v = 20'd14;
            5'd17: v = 20'd7;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            5'd20: v = 20'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic uop_t mk(input src_t a, input src_t b, input logic neg,
                                input logic first, input logic shr2, input dst_t dst);
        uop_t u;
        u.a = a;
        u.b = b;
        u.neg = neg;
        u.first = first;
        u.shr2 = shr2;
        u.dst = dst;
        return u;
    endfunction

    // Multiply-accumulate program. The first part serves the normal angle,
    // the second part the tangent angle.
    function automatic uop_t uop_of(input logic [UOP_W-1:0] idx);
        uop_t u;
        case (idx)
            6'd0:  u = mk(SRC_N0Y, SRC_NZ,  1'b0, 1'b1, 1'b0, DST_NONE);
            6'd1:  u = mk(SRC_N0Z, SRC_NY,  1'b1, 1'b0, 1'b0, DST_C0);
            6'd2:  u = mk(SRC_N0Z, SRC_NX,  1'b0, 1'b1, 1'b0, DST_NONE);
            6'd3:  u = mk(SRC_N0X, SRC_NZ,  1'b1, 1'b0, 1'b0, DST_C1);
            6'd4:  u = mk(SRC_N0X, SRC_NY,  1'b0, 1'b1, 1'b0, DST_NONE);
            6'd5:  u = mk(SRC_N0Y, SRC_NX,  1'b1, 1'b0, 1'b0, DST_C2);
            6'd6:  u = mk(SRC_C0,  SRC_C0,  1'b0, 1'b1, 1'b1, DST_NONE);
            6'd7:  u = mk(SRC_C1,  SRC_C1,  1'b0, 1'b0, 1'b1, DST_NONE);
            6'd8:  u = mk(SRC_C2,  SRC_C2,  1'b0, 1'b0, 1'b1, DST_SQ);
            6'd9:  u = mk(SRC_N0X, SRC_N0X, 1'b0, 1'b1, 1'b0, DST_NONE);
            6'd10: u = mk(SRC_N0Y, SRC_N0Y, 1'b0, 1'b0, 1'b0, DST_NONE);
            6'd11: u = mk(SRC_N0Z, SRC_N0Z, 1'b0, 1'b0, 1'b0, DST_DA);
            6'd12: u = mk(SRC_T0X, SRC_NX,  1'b0, 1'b1, 1'b0, DST_NONE);
            6'd13: u = mk(SRC_T0Y, SRC_NY,  1'b0, 1'b0, 1'b0, DST_NONE);
            6'd14: u = mk(SRC_T0Z, SRC_NZ,  1'b0, 1'b0, 1'b0, DST_DB);
            6'd15: u = mk(SRC_N0X, SRC_NX,  1'b0, 1'b1, 1'b0, DST_NONE);
            6'd16: u = mk(SRC_N0Y, SRC_NY,  1'b0, 1'b0, 1'b0, DST_NONE);
            6'd17: u = mk(SRC_N0Z, SRC_NZ,  1'b0, 1'b0, 1'b0, DST_DC);
            6'd18: u = mk(SRC_T0X, SRC_N0X, 1'b0, 1'b1, 1'b0, DST_NONE);
            6'd19: u = mk(SRC_T0Y, SRC_N0Y, 1'b0, 1'b0, 1'b0, DST_NONE);
            6'd20: u = mk(SRC_T0Z, SRC_N0Z, 1'b0, 1'b0, 1'b0, DST_DD);
            6'd21: u = mk(SRC_DA,  SRC_DB,  1'b0, 1'b1, 1'b0, DST_NONE);
            6'd22: u = mk(SRC_DC,  SRC_DD,  1'b1, 1'b0, 1'b0, DST_SGN);
            6'd23: u = mk(SRC_T0Y, SRC_TZ,  1'b0, 1'b1, 1'b0, DST_NONE);
            6'd24: u = mk(SRC_T0Z, SRC_TY,  1'b1, 1'b0, 1'b0, DST_C0);
            6'd25: u = mk(SRC_T0Z, SRC_TX,  1'b0, 1'b1, 1'b0, DST_NONE);
            6'd26: u = mk(SRC_T0X, SRC_TZ,  1'b1, 1'b0, 1'b0, DST_C1);
            6'd27: u = mk(SRC_T0X, SRC_TY,  1'b0, 1'b1, 1'b0, DST_NONE);
            6'd28: u = mk(SRC_T0Y, SRC_TX,  1'b1, 1'b0, 1'b0, DST_C2);
            6'd29: u = mk(SRC_C0,  SRC_C0,  1'b0, 1'b1, 1'b1, DST_NONE);
            6'd30: u = mk(SRC_C1,  SRC_C1,  1'b0, 1'b0, 1'b1, DST_NONE);
            6'd31: u = mk(SRC_C2,  SRC_C2,  1'b0, 1'b0, 1'b1, DST_SQ);
            6'd32: u = mk(SRC_T0X, SRC_TX,  1'b0, 1'b1, 1'b0, DST_NONE);
            6'd33: u = mk(SRC_T0Y, SRC_TY,  1'b0, 1'b0, 1'b0, DST_NONE);
            6'd34: u = mk(SRC_T0Z, SRC_TZ,  1'b0, 1'b0, 1'b0, DST_DC);
            6'd35: u = mk(SRC_N0X, SRC_C0,  1'b0, 1'b1, 1'b0, DST_NONE);
            6'd36: u = mk(SRC_N0Y, SRC_C1,  1'b0, 1'b0, 1'b0, DST_NONE);
            6'd37: u = mk(SRC_N0Z, SRC_C2,  1'b0, 1'b0, 1'b0, DST_SGN);
            default: u = mk(SRC_N0X, SRC_N0X, 1'b0, 1'b1, 1'b0, DST_NONE);
        endcase
        return u;
    endfunction

endpackage

>>> sv/rpfr_ctrl.sv
module rpfr_ctrl #(
    parameter int CORDIC_STEPS = rpfr_pkg::CORDIC_STEPS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output rpfr_pkg::cmd_t cmd
);
    import rpfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_SQRT, S_CINIT, S_CORD, S_KEEP, S_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic              phase_reg, phase_next;
    logic [UOP_W-1:0]  uop_reg, uop_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        uop_next       = uop_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.uop        = uop_reg;
        cmd.step       = cnt_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    phase_next = 1'b0;
                    uop_next   = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mac  = 1'b1;
                uop_next = uop_reg + 1'b1;
                if (uop_reg == (phase_reg ? UOP_Y_LAST : UOP_X_LAST))
                begin
                    cmd.sq_init = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(SQ_STEPS - 1))
                begin
                    state_next = S_CINIT;
                end
            end
            S_CINIT:
            begin
                cmd.cd_init = 1'b1;
                cnt_next    = '0;
                state_next  = S_CORD;
            end
            S_CORD:
            begin
                cmd.cd_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_KEEP;
                end
            end
            S_KEEP:
            begin
                if (!phase_reg)
                begin
                    cmd.keep_x = 1'b1;
                    phase_next = 1'b1;
                    uop_next   = UOP_Y_FIRST;
                    state_next = S_MAC;
                end
                else
                begin
                    cmd.keep_y = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            uop_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            uop_reg       <= uop_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A finished result never overwrites one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // An accepted sample always starts the multiply program at its first step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MAC && uop_reg == '0 && !phase_reg))
        else $error("sample accepted without starting the program");

    // The rotation counter never runs past the configured step count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CORD) |-> (cnt_reg <= STEP_W'(CORDIC_STEPS - 1)))
        else $error("rotation step out of range");

    // The multiply program stays within the part of the current angle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (phase_reg ? (uop_reg >= UOP_Y_FIRST && uop_reg <= UOP_Y_LAST)
                                             : (uop_reg <= UOP_X_LAST)))
        else $error("multiply step outside its program");

endmodule

>>> sv/rpfr_dp.sv
module rpfr_dp #(
    parameter int POS_WIDTH = rpfr_pkg::POS_WIDTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  rpfr_pkg::cmd_t                             cmd,
    input  logic [rpfr_pkg::in_dw(POS_WIDTH)-1:0]      in_data,
    input  logic                                       in_restart,
    output logic [rpfr_pkg::out_dw(POS_WIDTH)-1:0]     out_data
);
    import rpfr_pkg::*;

    localparam int OUT_DW = out_dw(POS_WIDTH);

    logic [2:0][POS_WIDTH-1:0] pos_in;
    logic [2:0][VEC_W-1:0]     norm_in, tan_in;

    logic                      have_ref_reg;
    logic [2:0][POS_WIDTH-1:0] ref_pos_reg;
    logic [2:0][VEC_W-1:0]     n0_reg, t0_reg, n_reg, t_reg;
    logic [2:0][POS_WIDTH-1:0] rel_reg;
    logic                      load_ref;

    logic signed [OPW-1:0]  c0_reg, c1_reg, c2_reg, da_reg, db_reg, dc_reg, dd_reg;
    logic signed [ACCW-1:0] acc_reg, acc_next, prod, term;
    logic signed [OPW-1:0]  opa, opb;
    logic                   sgn_reg;
    uop_t                   u;

    logic [SQ_W-1:0] sq_s_reg, sq_r_reg, sq_bit_reg, sq_sum;

    logic signed [CD_W-1:0] cd_x_reg, cd_y_reg, cd_xs, cd_ys, cd_x0, cd_y0;
    logic signed [Z_W-1:0]  z_reg, z_clip;
    logic [Z_W-1:0]         z_round;
    logic                   zy_reg, xneg_reg;
    logic [ANG_W-1:0]       amag;
    logic signed [ROT_W-1:0] ang, rot_x_reg;
    logic [OUT_DW-1:0]      out_data_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos_in[i]  = in_data[i*POS_WIDTH +: POS_WIDTH];
            norm_in[i] = in_data[3*POS_WIDTH + i*VEC_W +: VEC_W];
            tan_in[i]  = in_data[3*POS_WIDTH + 3*VEC_W + i*VEC_W +: VEC_W];
        end
    end

    assign load_ref = !have_ref_reg || in_restart;

    // Reference minus current position, saturated to the position range.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [POS_WIDTH:0] d;
                d = (load_ref ? (POS_WIDTH+1)'($signed(pos_in[i]))
                              : (POS_WIDTH+1)'($signed(ref_pos_reg[i])))
                    - (POS_WIDTH+1)'($signed(pos_in[i]));
                if (d[POS_WIDTH] != d[POS_WIDTH-1])
                begin
                    rel_reg[i] <= d[POS_WIDTH] ? {1'b1, {(POS_WIDTH-1){1'b0}}}
                                               : {1'b0, {(POS_WIDTH-1){1'b1}}};
                end
                else
                begin
                    rel_reg[i] <= d[POS_WIDTH-1:0];
                end
            end
            n_reg <= norm_in;
            t_reg <= tan_in;
            if (load_ref)
            begin
                ref_pos_reg <= pos_in;
                n0_reg      <= norm_in;
                t0_reg      <= tan_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_ref_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            have_ref_reg <= 1'b1;
        end
    end

    function automatic logic signed [OPW-1:0] pick(input src_t s,
        input logic [2:0][VEC_W-1:0] a0, input logic [2:0][VEC_W-1:0] b0,
        input logic [2:0][VEC_W-1:0] a1, input logic [2:0][VEC_W-1:0] b1,
        input logic signed [OPW-1:0] k0, input logic signed [OPW-1:0] k1,
        input logic signed [OPW-1:0] k2, input logic signed [OPW-1:0] ka,
        input logic signed [OPW-1:0] kb, input logic signed [OPW-1:0] kc,
        input logic signed [OPW-1:0] kd);
        logic signed [OPW-1:0] v;
        case (s)
            SRC_N0X: v = OPW'($signed(a0[0]));
            SRC_N0Y: v = OPW'($signed(a0[1]));
            SRC_N0Z: v = OPW'($signed(a0[2]));
            SRC_T0X: v = OPW'($signed(b0[0]));
            SRC_T0Y: v = OPW'($signed(b0[1]));
            SRC_T0Z: v = OPW'($signed(b0[2]));
            SRC_NX:  v = OPW'($signed(a1[0]));
            SRC_NY:  v = OPW'($signed(a1[1]));
            SRC_NZ:  v = OPW'($signed(a1[2]));
            SRC_TX:  v = OPW'($signed(b1[0]));
            SRC_TY:  v = OPW'($signed(b1[1]));
            SRC_TZ:  v = OPW'($signed(b1[2]));
            SRC_C0:  v = k0;
            SRC_C1:  v = k1;
            SRC_C2:  v = k2;
            SRC_DA:  v = ka;
            SRC_DB:  v = kb;
            SRC_DC:  v = kc;
            SRC_DD:  v = kd;
            default: v = '0;
        endcase
        return v;
    endfunction

    // One multiply and one accumulate per cycle.
    always_comb
    begin
        u    = uop_of(cmd.uop);
        opa  = pick(u.a, n0_reg, t0_reg, n_reg, t_reg,
                    c0_reg, c1_reg, c2_reg, da_reg, db_reg, dc_reg, dd_reg);
        opb  = pick(u.b, n0_reg, t0_reg, n_reg, t_reg,
                    c0_reg, c1_reg, c2_reg, da_reg, db_reg, dc_reg, dd_reg);
        prod = ACCW'(opa) * ACCW'(opb);
        term = u.shr2 ? (prod >>> 2) : prod;
        if (u.neg)
        begin
            term = -term;
        end
        acc_next = (u.first ? ACCW'(0) : acc_reg) + term;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac)
        begin
            acc_reg <= acc_next;
            case (u.dst)
                DST_C0:  c0_reg <= acc_next[OPW-1:0];
                DST_C1:  c1_reg <= acc_next[OPW-1:0];
                DST_C2:  c2_reg <= acc_next[OPW-1:0];
                DST_DA:  da_reg <= acc_next[OPW-1:0];
                DST_DB:  db_reg <= acc_next[OPW-1:0];
                DST_DC:  dc_reg <= acc_next[OPW-1:0];
                DST_DD:  dd_reg <= acc_next[OPW-1:0];
                DST_SGN: sgn_reg <= acc_next[ACCW-1];
                default:
                begin
                end
            endcase
        end
        if (cmd.mac && u.dst == DST_SQ)
        begin
            sq_s_reg <= acc_next[SQ_W-1:0];
        end
        else if (cmd.sq_step && sq_s_reg >= sq_sum)
        begin
            sq_s_reg <= sq_s_reg - sq_sum;
        end
    end

    // Integer square root, one result bit per cycle.
    assign sq_sum = sq_r_reg + sq_bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sq_init)
        begin
            sq_r_reg   <= '0;
            sq_bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end
        else if (cmd.sq_step)
        begin
            sq_r_reg   <= (sq_s_reg >= sq_sum) ? ((sq_r_reg >> 1) + sq_bit_reg)
                                               : (sq_r_reg >> 1);
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    // Vectoring rotation of (halved dot, halved cross magnitude).
    assign cd_x0 = CD_W'(dc_reg >>> 1);
    assign cd_y0 = CD_W'($signed({1'b0, sq_r_reg[31:0]}));
    assign cd_xs = cd_x_reg >>> cmd.step;
    assign cd_ys = cd_y_reg >>> cmd.step;

    always_ff @(posedge clk)
    begin
        if (cmd.cd_init)
        begin
            zy_reg   <= (sq_r_reg == '0);
            xneg_reg <= dc_reg[OPW-1];
            if (dc_reg[OPW-1])
            begin
                cd_x_reg <= cd_y0;
                cd_y_reg <= -cd_x0;
                z_reg    <= Z_W'(ANG_QUARTER);
            end
            else
            begin
                cd_x_reg <= cd_x0;
                cd_y_reg <= cd_y0;
                z_reg    <= '0;
            end
        end
        else if (cmd.cd_step)
        begin
            if (!cd_y_reg[CD_W-1])
            begin
                cd_x_reg <= cd_x_reg + cd_ys;
                cd_y_reg <= cd_y_reg - cd_xs;
                z_reg    <= z_reg + Z_W'(atan_fine(cmd.step));
            end
            else
            begin
                cd_x_reg <= cd_x_reg - cd_ys;
                cd_y_reg <= cd_y_reg + cd_xs;
                z_reg    <= z_reg - Z_W'(atan_fine(cmd.step));
            end
        end
    end

    // Fine angle to 1/64 degree, clamped, then signed.
    always_comb
    begin
        z_clip  = z_reg[Z_W-1] ? Z_W'(0) : z_reg;
        z_round = (Z_W'(z_clip) + Z_W'(128)) >> 8;
        if (zy_reg)
        begin
            amag = xneg_reg ? ANG_W'(ANG_MAX) : '0;
        end
        else if (z_round > Z_W'(ANG_MAX))
        begin
            amag = ANG_W'(ANG_MAX);
        end
        else
        begin
            amag = z_round[ANG_W-1:0];
        end
        ang = sgn_reg ? -ROT_W'(amag) : ROT_W'(amag);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.keep_x)
        begin
            rot_x_reg <= ang;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= OUT_DW'({ang, rot_x_reg, rel_reg[2], rel_reg[1], rel_reg[0]});
        end
    end

    assign out_data = out_data_reg;

    // The final rotation angle never exceeds a half turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.keep_x || cmd.keep_y) |-> (amag <= ANG_W'(ANG_MAX)))
        else $error("angle magnitude out of range");

endmodule

>>> sv/relative_pose_from_reference_core.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pos, normal, tangent; tuser: restart
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: rel position, rot_x, rot_y
//
// The next input transfer can be taken in the same cycle as the result becomes
// valid. The processing time of a sample is set by the single shared
// multiply-accumulate unit (38 products), the bit-serial square root and the
// shared rotation unit, run once per angle.
// Reset is asynchronous and active low; it clears the controller and the
// reference-present flag, so the first sample after reset becomes the reference.
// A result waits in its own register; the next input transfer is taken while
// that result still waits, and the block only stalls at the end of a sample if
// the previous result has not yet been taken.
module relative_pose_from_reference_core #(
    parameter int POS_WIDTH    = rpfr_pkg::POS_WIDTH_DEF,
    parameter int CORDIC_STEPS = rpfr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tan_x, tan_y, tan_z, zero fill
    input  logic [rpfr_pkg::in_dw(POS_WIDTH)-1:0]  s_axis_tdata,
    // restart
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // rel_x, rel_y, rel_z, rot_x, rot_y, zero fill
    output logic [rpfr_pkg::out_dw(POS_WIDTH)-1:0] m_axis_tdata
);
    import rpfr_pkg::*;

    cmd_t cmd;

    // The controller sequences the multiply program, the square root and the
    // rotation steps for each of the two angles, then hands the result over.
    rpfr_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .cmd      (cmd)
    );

    // The datapath keeps the reference sample and all arithmetic units.
    rpfr_dp #(
        .POS_WIDTH(POS_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_axis_tdata),
        .in_restart(s_axis_tuser),
        .out_data  (m_axis_tdata)
    );

endmodule

>>> tb/relative_pose_from_reference_core_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the relative pose core, predicts every result from
// the accepted samples and compares field by field, oldest first.
module relative_pose_from_reference_core_checker (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  s_axis_tvalid,
    input  logic                                                  s_axis_tready,
    input  logic [rpfr_pkg::in_dw(rpfr_pkg::POS_WIDTH_DEF)-1:0]   s_axis_tdata,
    input  logic                                                  s_axis_tuser,
    input  logic                                                  m_axis_tvalid,
    input  logic                                                  m_axis_tready,
    input  logic [rpfr_pkg::out_dw(rpfr_pkg::POS_WIDTH_DEF)-1:0]  m_axis_tdata,
    output int                                                    fail_count,
    output int                                                    pending_count
);
    import rpfr_pkg::*;

    localparam int PW = POS_WIDTH_DEF;

    typedef struct packed {
        logic signed [ROT_W-1:0] rot_y;
        logic signed [ROT_W-1:0] rot_x;
        logic signed [PW-1:0]    rel_z;
        logic signed [PW-1:0]    rel_y;
        logic signed [PW-1:0]    rel_x;
    } pose_t;

    // Fine angle table, 1/16384 degree.
    localparam longint ATAN_TBL [0:15] = '{737280, 435242, 229970, 116736, 58595,
        29326, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

    longint base_pos [3];
    longint base_nrm [3];
    longint base_tan [3];
    bit     base_valid;
    pose_t  expected_poses [$];

    assign pending_count = expected_poses.size();

    function automatic void cross_of(input longint p [3], input longint q [3],
                                     output longint o [3]);
        o[0] = p[1] * q[2] - p[2] * q[1];
        o[1] = p[2] * q[0] - p[0] * q[2];
        o[2] = p[0] * q[1] - p[1] * q[0];
    endfunction

    function automatic longint dot_of(input longint p [3], input longint q [3]);
        return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
    endfunction

    function automatic longint unsigned root_of(input longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Unsigned angle between two vectors, 1/64 degree, by vectoring rotation.
    function automatic longint angle_between(input longint r [3], input longint v [3]);
        longint c [3];
        longint x, y, z, xn, yn, t;
        longint unsigned s, a;
        cross_of(r, v, c);
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = (c[i] < 0) ? -c[i] : c[i];
            s += (a * a) >> 2;
        end
        y = root_of(s);
        x = dot_of(r, v) >>> 1;
        z = 0;
        if (y == 0)
            return (x < 0) ? ANG_MAX : 0;
        if (x < 0)
        begin
            // Turn a backward-pointing operand by a quarter turn first.
            t = x;
            x = y;
            y = -t;
            z = ANG_QUARTER;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            if (y >= 0)
            begin
                xn = x + (y >>> i);
                yn = y - (x >>> i);
                z += ATAN_TBL[i];
            end
            else
            begin
                xn = x - (y >>> i);
                yn = y + (x >>> i);
                z -= ATAN_TBL[i];
            end
            x = xn;
            y = yn;
        end
        if (z < 0) z = 0;
        z = (z + 128) >>> 8;
        return (z > ANG_MAX) ? ANG_MAX : z;
    endfunction

    function automatic pose_t pose_of(input logic [in_dw(PW)-1:0] d, input logic restart);
        longint p [3];
        longint n [3];
        longint t [3];
        longint tt [3];
        longint diff, ax, ay, lhs_a, lhs_b, rhs_a, rhs_b;
        pose_t  o;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = longint'($signed(d[i*PW +: PW]));
            n[i] = longint'($signed(d[3*PW + i*VEC_W +: VEC_W]));
            t[i] = longint'($signed(d[3*PW + (3+i)*VEC_W +: VEC_W]));
        end
        if (!base_valid || restart)
        begin
            base_pos = p;
            base_nrm = n;
            base_tan = t;
            base_valid = 1'b1;
        end
        for (int i = 0; i < 3; i++)
        begin
            diff = base_pos[i] - p[i];
            if (diff > (64'sd1 <<< (PW-1)) - 1) diff = (64'sd1 <<< (PW-1)) - 1;
            if (diff < -(64'sd1 <<< (PW-1))) diff = -(64'sd1 <<< (PW-1));
            if (i == 0) o.rel_x = diff[PW-1:0];
            else if (i == 1) o.rel_y = diff[PW-1:0];
            else o.rel_z = diff[PW-1:0];
        end
        // Sign of (n0 x t0).(n0 x n) = (n0.n0)(t0.n) - (n0.n)(t0.n0); the
        // products stay well inside 128 bits, so compare them exactly.
        ax = angle_between(base_nrm, n);
        lhs_a = dot_of(base_nrm, base_nrm);
        lhs_b = dot_of(base_tan, n);
        rhs_a = dot_of(base_nrm, n);
        rhs_b = dot_of(base_tan, base_nrm);
        if (128'(signed'(lhs_a)) * 128'(signed'(lhs_b))
            < 128'(signed'(rhs_a)) * 128'(signed'(rhs_b)))
            ax = -ax;
        ay = angle_between(base_tan, t);
        cross_of(base_tan, t, tt);
        if (dot_of(base_nrm, tt) < 0)
            ay = -ay;
        o.rot_x = ax[ROT_W-1:0];
        o.rot_y = ay[ROT_W-1:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pose_t want, got;
        if (!rst_n)
        begin
            base_valid <= 1'b0;
            fail_count <= 0;
            expected_poses.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_poses.insert(expected_poses.size(),
                                      pose_of(s_axis_tdata, s_axis_tuser));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = pose_t'(m_axis_tdata[$bits(pose_t)-1:0]);
                if (expected_poses.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_poses.pop_front();
                    if (want !== got)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: rel %0d %0d %0d rot %0d %0d, got rel %0d %0d %0d rot %0d %0d",
                                want.rel_x, want.rel_y, want.rel_z, want.rot_x, want.rot_y,
                                got.rel_x, got.rel_y, got.rel_z, got.rot_x, got.rot_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/relative_pose_from_reference_core_test.sv
`timescale 1ns / 1ps

module relative_pose_from_reference_core_test;
    import rpfr_pkg::*;

    localparam int PW = POS_WIDTH_DEF;
    localparam int DW = in_dw(PW);

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [DW-1:0]           s_axis_tdata;
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [out_dw(PW)-1:0]   m_axis_tdata;
    int                      fail_count;
    int                      pending_count;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;

    relative_pose_from_reference_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    relative_pose_from_reference_core_checker pose_check (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Receiver: random stalls, plus a long hold-off when hold_cycles is set.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // A vector component: mostly in range, sometimes any 16 bit pattern.
    function automatic logic [VEC_W-1:0] rand_comp();
        case ($urandom_range(9))
            0: return 16'(16384);
            1: return 16'(-16384);
            2: return VEC_W'($urandom);
            3: return '0;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [PW-1:0] rand_pos();
        case ($urandom_range(7))
            0: return {1'b0, {(PW-1){1'b1}}};
            1: return {1'b1, {(PW-1){1'b0}}};
            2: return PW'($urandom_range(2000)) - PW'(1000);
            default: return PW'($urandom);
        endcase
    endfunction

    // One transfer; valid stays high back to back unless the sender idles.
    task automatic send_sample(input logic [PW-1:0] p [3], input logic [VEC_W-1:0] n [3],
                               input logic [VEC_W-1:0] t [3], input logic restart);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= restart;
        s_axis_tdata  <= DW'({t[2], t[1], t[0], n[2], n[1], n[0], p[2], p[1], p[0]});
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_vecs(input logic [VEC_W-1:0] nx, ny, nz, tx, ty, tz,
                             input logic restart);
        logic [PW-1:0]    p [3];
        logic [VEC_W-1:0] n [3];
        logic [VEC_W-1:0] t [3];
        p = '{rand_pos(), rand_pos(), rand_pos()};
        n = '{nx, ny, nz};
        t = '{tx, ty, tz};
        send_sample(p, n, t, restart);
    endtask

    task automatic send_random(input logic restart);
        send_vecs(rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), rand_comp(), rand_comp(), restart);
    endtask

    task automatic run_phase(input int count);
        for (int i = 0; i < count; i++)
            send_random($urandom_range(15) == 0);
    endtask

    initial
    begin
        logic [PW-1:0]    p [3];
        logic [VEC_W-1:0] n [3];
        logic [VEC_W-1:0] t [3];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        hold_cycles   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the first sample becomes the reference even without restart.
        p = '{{1'b0, {(PW-1){1'b1}}}, {1'b1, {(PW-1){1'b0}}}, '0};
        n = '{16'(16384), 16'd0, 16'd0};
        t = '{16'd0, 16'(16384), 16'd0};
        send_sample(p, n, t, 1'b0);
        // Position saturation both ways.
        p = '{{1'b1, {(PW-1){1'b0}}}, {1'b0, {(PW-1){1'b1}}}, '1};
        send_sample(p, n, t, 1'b0);
        // Identical vectors, opposite vectors, quarter turns of either sign.
        send_vecs(16'(16384), 16'd0, 16'd0, 16'd0, 16'(16384), 16'd0, 1'b0);
        send_vecs(16'(-16384), 16'd0, 16'd0, 16'd0, 16'(-16384), 16'd0, 1'b0);
        send_vecs(16'd0, 16'(16384), 16'd0, 16'(-16384), 16'd0, 16'd0, 1'b0);
        send_vecs(16'd0, 16'(-16384), 16'd0, 16'(16384), 16'd0, 16'd0, 1'b0);
        send_vecs(16'd0, 16'd0, 16'(16384), 16'd0, 16'd0, 16'(16384), 1'b0);
        send_vecs(16'd0, 16'd0, 16'(-16384), 16'd0, 16'd0, 16'(-16384), 1'b0);
        // Zero vectors, all-ones and extreme bit patterns.
        send_vecs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_vecs(16'h7fff, 16'h8000, 16'hffff, 16'h8000, 16'h7fff, 16'hffff, 1'b0);
        // Zero reference vectors: every angle collapses to zero.
        send_vecs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        send_vecs(16'(16384), 16'd0, 16'd0, 16'd0, 16'(16384), 16'd0, 1'b0);
        // Back to a unit reference and small tilts.
        send_vecs(16'(16384), 16'd0, 16'd0, 16'd0, 16'(16384), 16'd0, 1'b1);
        send_vecs(16'(16380), 16'd200, 16'd0, 16'(-200), 16'(16380), 16'd0, 1'b0);
        send_vecs(16'(16380), 16'(-200), 16'd0, 16'd200, 16'(16380), 16'd0, 1'b0);
        send_vecs(16'(16380), 16'd0, 16'd5, 16'd0, 16'(16380), 16'(-5), 1'b0);
        send_vecs(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
        send_vecs(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 1'b0);

        // Long receiver hold-off while samples keep coming: the core fills up.
        hold_cycles <= 2000;
        run_phase(8);
        // Sender pause until all outstanding results are back.
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge clk);

        send_idle_pct = 9;
        recv_idle_pct = 52;
        run_phase(360);
        send_idle_pct = 52;
        recv_idle_pct = 9;
        run_phase(360);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(360);
        s_axis_tvalid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Slowest run: about 1100 samples, lengthened by stalls.
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
